@@ rtl/lbfv_pkg.sv @@
`default_nettype none
package lbfv_pkg;

    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_FRAME_ENERGY = 3'd0;
    localparam t_cfg_idx REG_FRAME_PX     = 3'd1;
    localparam t_cfg_idx REG_FRAME_PY     = 3'd2;
    localparam t_cfg_idx REG_FRAME_PZ     = 3'd3;
    localparam t_cfg_idx REG_FRAME_MASS   = 3'd4;

    localparam logic CMD_INTO = 1'b0;
    localparam logic CMD_OUT  = 1'b1;

endpackage
`default_nettype wire

@@ rtl/lorentz_boost_four_vector.sv @@
`default_nettype none
// Lorentz boost of one four-vector per item against a configured frame
// four-vector and mass, signed fixed point, saturating. Fully pipelined: one
// item per cycle while o_stall is low. The energy divider and the three
// momentum dividers are restoring dividers that resolve one quotient bit per
// stage. A two-entry output buffer keeps the input open while a result waits.
// Frame registers may be written only while no item is in flight; they apply
// to items accepted from the next cycle on.
module lorentz_boost_four_vector #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_command,
    input  wire logic signed [WORD_WIDTH-1:0]  i_in_energy,
    input  wire logic signed [WORD_WIDTH-1:0]  i_in_px,
    input  wire logic signed [WORD_WIDTH-1:0]  i_in_py,
    input  wire logic signed [WORD_WIDTH-1:0]  i_in_pz,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [WORD_WIDTH-1:0]       o_out_energy,
    output logic signed [WORD_WIDTH-1:0]       o_out_px,
    output logic signed [WORD_WIDTH-1:0]       o_out_py,
    output logic signed [WORD_WIDTH-1:0]       o_out_pz,
    output logic                               o_bypassed,
    output logic                               o_saturated,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire lbfv_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic [WORD_WIDTH-1:0]         i_cfg_data
);

    localparam int W  = WORD_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;
    localparam int MW = 2 * W + 1;

    localparam logic [W-1:0] ONE  = {{(W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic                v;
        logic                cmd;
        logic                byp;
        logic signed [W-1:0] e;
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic signed [W-1:0] pz;
    } t_base;

    typedef struct packed {
        t_base       b;
        logic        neg;
    } t_sb1;

    typedef struct packed {
        t_base               b;
        logic signed [W-1:0] eo;
        logic                clip;
    } t_mid;

    typedef struct packed {
        t_mid       m;
        logic [2:0] neg;
    } t_sb2;

    typedef struct packed {
        logic [W-1:0] e;
        logic [W-1:0] px;
        logic [W-1:0] py;
        logic [W-1:0] pz;
        logic         byp;
        logic         sat;
    } t_res;

    // frame registers
    logic signed [W-1:0] r_frame_energy;
    logic signed [W-1:0] r_frame_p [0:2];
    logic signed [W-1:0] r_frame_mass;
    logic [W-1:0]        r_mass_mag;
    logic                r_mass_neg;
    logic [W:0]          r_den_mag;
    logic                r_den_neg;
    logic signed [W:0]   den_c;
    logic                deg;

    assign o_cfg_ready = 1'b1;
    assign den_c = {r_frame_mass[W-1], r_frame_mass} + {r_frame_energy[W-1], r_frame_energy};
    assign deg   = (r_frame_mass == '0) || (den_c == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_energy <= ONE;
            r_frame_p[0]   <= '0;
            r_frame_p[1]   <= '0;
            r_frame_p[2]   <= '0;
            r_frame_mass   <= ONE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lbfv_pkg::REG_FRAME_ENERGY: r_frame_energy <= i_cfg_data;
                lbfv_pkg::REG_FRAME_PX:     r_frame_p[0]   <= i_cfg_data;
                lbfv_pkg::REG_FRAME_PY:     r_frame_p[1]   <= i_cfg_data;
                lbfv_pkg::REG_FRAME_PZ:     r_frame_p[2]   <= i_cfg_data;
                lbfv_pkg::REG_FRAME_MASS:   r_frame_mass   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_mass_mag <= r_frame_mass[W-1] ? W'(-r_frame_mass) : W'(r_frame_mass);
        r_mass_neg <= r_frame_mass[W-1];
        r_den_mag  <= den_c[W] ? (W+1)'(-den_c) : (W+1)'(den_c);
        r_den_neg  <= den_c[W];
    end

    // pipeline control
    logic r_skid_v;
    logic r_out_v;
    logic en;
    logic push;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    // stage registers
    t_base                r1;
    logic signed [PW-1:0] r1_pe;
    logic signed [PW-1:0] r1_pp [0:2];
    t_base                r2;
    logic signed [SW-1:0] r2_s0, r2_s1;
    t_base                r3;
    logic signed [SW-1:0] r3_q;
    t_sb1                 r4;
    logic [SW-1:0]        r4_qmag;
    t_sb1                 r_sb1 [0:W];
    t_mid                 r5;
    t_mid                 r6;
    logic signed [W:0]    r6_s;
    t_mid                 r7;
    logic signed [MW-1:0] r7_prod [0:2];
    t_sb2                 r8;
    logic [MW-1:0]        r8_mag [0:2];
    t_sb2                 r_sb2 [0:W];
    t_sb2                 r9;
    logic signed [W:0]    r9_t [0:2];
    logic [2:0]           r9_ovf;

    t_base                n1;
    logic signed [SW-1:0] x_pe, x_pp0, x_pp1, x_pp2, x_s12;
    logic [W-1:0]         d1_quo;
    logic                 d1_ovf;
    t_mid                 n5;
    logic [W-1:0]         d2_quo [0:2];
    logic [2:0]           d2_ovf;
    logic signed [W:0]    n9_t [0:2];
    logic [2:0]           n8_neg;

    assign n1 = '{v: i_valid, cmd: i_command, byp: deg, e: i_in_energy,
                  px: i_in_px, py: i_in_py, pz: i_in_pz};

    assign x_pe  = SW'(r1_pe);
    assign x_pp0 = SW'(r1_pp[0]);
    assign x_pp1 = SW'(r1_pp[1]);
    assign x_pp2 = SW'(r1_pp[2]);
    assign x_s12 = x_pp1 + x_pp2;

    // energy saturation after the first division
    always_comb begin
        n5.b    = r_sb1[W].b;
        n5.clip = 1'b0;
        n5.eo   = '0;
        if (r_sb1[W].neg) begin
            n5.clip = d1_ovf || (d1_quo > MINN);
            n5.eo   = n5.clip ? MINN : -d1_quo;
        end else begin
            n5.clip = d1_ovf || d1_quo[W-1];
            n5.eo   = n5.clip ? MAXP : d1_quo;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
        assign n8_neg[i] = r7_prod[i][MW-1] ^ r_den_neg ^ (r7.b.cmd == lbfv_pkg::CMD_INTO);
        assign n9_t[i]   = r_sb2[W].neg[i] ? -{1'b0, d2_quo[i]} : {1'b0, d2_quo[i]};

        lbfv_div #(.NW(MW), .DW(W + 1), .QW(W)) u_div2 (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r8_mag[i]),
            .i_den (r_den_mag),
            .o_quo (d2_quo[i]),
            .o_ovf (d2_ovf[i])
        );
    end

    lbfv_div #(.NW(SW), .DW(W), .QW(W)) u_div1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_qmag),
        .i_den (r_mass_mag),
        .o_quo (d1_quo),
        .o_ovf (d1_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1.v <= 1'b0;
            r2.v <= 1'b0;
            r3.v <= 1'b0;
            r4.b.v <= 1'b0;
            for (int k = 0; k <= W; k++) begin
                r_sb1[k].b.v   <= 1'b0;
                r_sb2[k].m.b.v <= 1'b0;
            end
            r5.b.v <= 1'b0;
            r6.b.v <= 1'b0;
            r7.b.v <= 1'b0;
            r8.m.b.v <= 1'b0;
            r9.m.b.v <= 1'b0;
        end else if (en) begin
            r1    <= n1;
            r1_pe <= PW'(r_frame_energy) * PW'(i_in_energy);
            r1_pp[0] <= PW'(r_frame_p[0]) * PW'(i_in_px);
            r1_pp[1] <= PW'(r_frame_p[1]) * PW'(i_in_py);
            r1_pp[2] <= PW'(r_frame_p[2]) * PW'(i_in_pz);

            r2    <= r1;
            r2_s0 <= (r1.cmd == lbfv_pkg::CMD_OUT) ? x_pe + x_pp0 : x_pe - x_pp0;
            r2_s1 <= (r1.cmd == lbfv_pkg::CMD_OUT) ? x_s12 : -x_s12;

            r3   <= r2;
            r3_q <= r2_s0 + r2_s1;

            r4.b    <= r3;
            r4.neg  <= r3_q[SW-1] ^ r_mass_neg;
            r4_qmag <= r3_q[SW-1] ? SW'(-r3_q) : SW'(r3_q);

            r_sb1[0] <= r4;
            for (int k = 1; k <= W; k++) r_sb1[k] <= r_sb1[k-1];

            r5 <= n5;

            r6   <= r5;
            r6_s <= (W+1)'(r5.b.e) + (W+1)'(r5.eo);

            r7 <= r6;
            for (int i = 0; i < 3; i++) r7_prod[i] <= MW'(r6_s) * MW'(r_frame_p[i]);

            r8.m   <= r7;
            r8.neg <= n8_neg;
            for (int i = 0; i < 3; i++) begin
                r8_mag[i] <= r7_prod[i][MW-1] ? MW'(-r7_prod[i]) : MW'(r7_prod[i]);
            end

            r_sb2[0] <= r8;
            for (int k = 1; k <= W; k++) r_sb2[k] <= r_sb2[k-1];

            r9     <= r_sb2[W];
            r9_ovf <= d2_ovf;
            for (int i = 0; i < 3; i++) r9_t[i] <= n9_t[i];
        end
    end

    // momentum add and saturation
    logic signed [W-1:0] fp  [0:2];
    logic signed [W+1:0] sum [0:2];
    logic [W-1:0]        pv  [0:2];
    logic [2:0]          pclip;
    t_res                fin;

    assign fp[0] = r9.m.b.px;
    assign fp[1] = r9.m.b.py;
    assign fp[2] = r9.m.b.pz;

    for (genvar i = 0; i < 3; i++) begin : g_sat
        assign sum[i] = (W+2)'(fp[i]) + (W+2)'(r9_t[i]);
        always_comb begin
            if (r9_ovf[i]) begin
                pclip[i] = 1'b1;
                pv[i]    = r9.neg[i] ? MINN : MAXP;
            end else if ((sum[i][W+1:W-1] != '0) && (sum[i][W+1:W-1] != '1)) begin
                pclip[i] = 1'b1;
                pv[i]    = sum[i][W+1] ? MINN : MAXP;
            end else begin
                pclip[i] = 1'b0;
                pv[i]    = sum[i][W-1:0];
            end
        end
    end

    always_comb begin
        if (r9.m.b.byp) begin
            fin = '{e: r9.m.b.e, px: r9.m.b.px, py: r9.m.b.py, pz: r9.m.b.pz,
                    byp: 1'b1, sat: 1'b0};
        end else begin
            fin = '{e: r9.m.eo, px: pv[0], py: pv[1], pz: pv[2],
                    byp: 1'b0, sat: r9.m.clip | (|pclip)};
        end
    end

    assign push = en && r9.m.b.v;

    // output register with skid entry
    t_res r_out;
    t_res r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            r_out_v  <= r_skid_v || push;
            r_skid_v <= 1'b0;
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || !i_stall) begin
            r_out <= r_skid_v ? r_skid : fin;
        end else if (push) begin
            r_skid <= fin;
        end
    end

    assign o_valid      = r_out_v;
    assign o_out_energy = r_out.e;
    assign o_out_px     = r_out.px;
    assign o_out_py     = r_out.py;
    assign o_out_pz     = r_out.pz;
    assign o_bypassed   = r_out.byp;
    assign o_saturated  = r_out.sat;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry full with empty output register");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall && push) |=> r_skid_v)
        else $error("result arriving at stalled output was not buffered");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> (!r_skid_v && r_out_v))
        else $error("skid entry did not drain");

    a_byp_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bypassed) |-> !o_saturated)
        else $error("bypassed item flagged saturated");

endmodule
`default_nettype wire

@@ rtl/lbfv_div.sv @@
`default_nettype none
module lbfv_div #(
    parameter int NW = 66,
    parameter int DW = 32,
    parameter int QW = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo,
    output logic               o_ovf
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_d   [0:QW-1];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_ovf [0:QW];

    logic [CW-1:0] n_rem [1:QW];
    logic [QW-1:0] n_q   [1:QW];
    logic          n_ovf0;

    // quotient would need more than QW bits
    assign n_ovf0 = CW'(i_num) >= (CW'(i_den) << QW);

    for (genvar k = 1; k <= QW; k++) begin : g_stg
        logic [CW-1:0] sh;
        logic [CW:0]   diff;
        assign sh       = CW'(r_d[k-1]) << (QW - k);
        assign diff     = {1'b0, r_rem[k-1]} - {1'b0, sh};
        assign n_rem[k] = diff[CW] ? r_rem[k-1] : diff[CW-1:0];
        assign n_q[k]   = r_q[k-1] | (diff[CW] ? '0 : (QW'(1) << (QW - k)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(i_num);
            r_d[0]   <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= n_ovf0;
            for (int k = 1; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_d[k]   <= r_d[k-1];
            end
            for (int k = 1; k <= QW; k++) begin
                r_q[k]   <= n_q[k];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_q[QW];
    assign o_ovf = r_ovf[QW];

endmodule
`default_nettype wire

@@ dv/lorentz_boost_four_vector_tb.sv @@
module lorentz_boost_four_vector_tb;

    localparam int W = 32;
    localparam int LAT = 2 * W + 12;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [W-1:0] e;
        logic [W-1:0] px;
        logic [W-1:0] py;
        logic [W-1:0] pz;
        logic         byp;
        logic         sat;
    } t_boosted;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_command = 1'b0;
    logic signed [W-1:0] i_in_energy = '0, i_in_px = '0, i_in_py = '0, i_in_pz = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [W-1:0] o_out_energy, o_out_px, o_out_py, o_out_pz;
    logic o_bypassed, o_saturated;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    lbfv_pkg::t_cfg_idx i_cfg_index = lbfv_pkg::REG_FRAME_ENERGY;
    logic [W-1:0] i_cfg_data = '0;

    lorentz_boost_four_vector DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // frame registers, predictor copy
    logic signed [W-1:0] fr_e = 32'sh10000, fr_px = 0, fr_py = 0, fr_pz = 0;
    logic signed [W-1:0] fr_m = 32'sh10000;

    t_boosted pending[$];
    int errors = 0;
    longint cycles = 0;
    int hold_off = 0;
    int stall_mode = 0;

    function automatic logic signed [W-1:0] clip_word(logic signed [191:0] v, ref logic hit);
        logic signed [191:0] hi, lo;
        hi = 192'sd2147483647;
        lo = -192'sd2147483648;
        if (v > hi) begin
            hit = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < lo) begin
            hit = 1'b1;
            return 32'sh80000000;
        end
        return v[W-1:0];
    endfunction

    function automatic t_boosted boost_vector(logic cmd, logic signed [W-1:0] e,
            logic signed [W-1:0] px, logic signed [W-1:0] py, logic signed [W-1:0] pz);
        t_boosted r;
        logic signed [191:0] den, dot, q, s, t;
        logic signed [191:0] fp[3];
        logic signed [191:0] p[3];
        logic signed [W-1:0] eo, po[3];
        logic hit;
        hit = 1'b0;
        den = 192'(fr_m) + 192'(fr_e);
        if (fr_m == 0 || den == 0) begin
            r = '{e: e, px: px, py: py, pz: pz, byp: 1'b1, sat: 1'b0};
            return r;
        end
        fp[0] = 192'(fr_px); fp[1] = 192'(fr_py); fp[2] = 192'(fr_pz);
        p[0] = 192'(px); p[1] = 192'(py); p[2] = 192'(pz);
        dot = fp[0] * p[0] + fp[1] * p[1] + fp[2] * p[2];
        if (cmd == lbfv_pkg::CMD_INTO) dot = -dot;
        q = 192'(fr_e) * 192'(e) + dot;
        eo = clip_word(q / 192'(fr_m), hit);
        s = 192'(e) + 192'(eo);
        for (int i = 0; i < 3; i++) begin
            t = (s * fp[i]) / den;
            if (cmd == lbfv_pkg::CMD_INTO) t = -t;
            po[i] = clip_word(p[i] + t, hit);
        end
        r = '{e: eo, px: po[0], py: po[1], pz: po[2], byp: 1'b0, sat: hit};
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall pattern plus a long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 1) == 0);
            endcase
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        end
    end

    always @(posedge i_clk) begin
        t_boosted want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending.size() == 0) begin
                report_mismatch("unexpected item", o_out_energy, '0);
            end else begin
                want = pending.pop_front();
                if (o_out_energy !== want.e) report_mismatch("out_energy", o_out_energy, want.e);
                if (o_out_px !== want.px) report_mismatch("out_px", o_out_px, want.px);
                if (o_out_py !== want.py) report_mismatch("out_py", o_out_py, want.py);
                if (o_out_pz !== want.pz) report_mismatch("out_pz", o_out_pz, want.pz);
                if (o_bypassed !== want.byp)
                    report_mismatch("bypassed", W'(o_bypassed), W'(want.byp));
                if (o_saturated !== want.sat)
                    report_mismatch("saturated", W'(o_saturated), W'(want.sat));
            end
        end
    end

    int burst_left = 0;

    task automatic send_vector(logic cmd, logic [W-1:0] e, logic [W-1:0] px,
            logic [W-1:0] py, logic [W-1:0] pz, bit gaps = 1);
        if (gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_in_energy <= e;
        i_in_px <= px;
        i_in_py <= py;
        i_in_pz <= pz;
        do @(posedge i_clk); while (o_stall);
        pending.push_back(boost_vector(cmd, e, px, py, pz));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(lbfv_pkg::t_cfg_idx idx, logic [W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            lbfv_pkg::REG_FRAME_ENERGY: fr_e = value;
            lbfv_pkg::REG_FRAME_PX:     fr_px = value;
            lbfv_pkg::REG_FRAME_PY:     fr_py = value;
            lbfv_pkg::REG_FRAME_PZ:     fr_pz = value;
            lbfv_pkg::REG_FRAME_MASS:   fr_m = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_frame(logic [W-1:0] e, logic [W-1:0] px, logic [W-1:0] py,
            logic [W-1:0] pz, logic [W-1:0] m);
        wait_drained();
        write_reg(lbfv_pkg::REG_FRAME_ENERGY, e);
        write_reg(lbfv_pkg::REG_FRAME_PX, px);
        write_reg(lbfv_pkg::REG_FRAME_PY, py);
        write_reg(lbfv_pkg::REG_FRAME_PZ, pz);
        write_reg(lbfv_pkg::REG_FRAME_MASS, m);
    endtask

    function automatic logic [W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 32'h1fffff)) - 32'sh100000);
        endcase
    endfunction

    task automatic test_directed();
        logic [W-1:0] ext[5] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h10000};
        set_frame(32'h20000, 32'h10000, 32'h8000, 32'hffff0000, 32'h1bb67);
        for (int i = 0; i < 5; i++) begin
            send_vector(lbfv_pkg::CMD_INTO, ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5],
                        ext[(i + 3) % 5]);
            send_vector(lbfv_pkg::CMD_OUT, ext[i], ext[(i + 4) % 5], ext[(i + 3) % 5],
                        ext[(i + 2) % 5]);
        end
        send_vector(lbfv_pkg::CMD_INTO, 32'h30000, 32'h10000, 32'h0, 32'h0);
        send_vector(lbfv_pkg::CMD_OUT, 32'h30000, 32'h10000, 32'h0, 32'h0);
        // zero mass passes the vector through
        set_frame(32'h10000, 32'h1, 32'h2, 32'h3, 32'h0);
        send_vector(lbfv_pkg::CMD_INTO, 32'h12345678, 32'h80000000, 32'h7fffffff,
                    32'hdeadbeef);
        send_vector(lbfv_pkg::CMD_OUT, 32'h1, 32'h2, 32'h3, 32'h4);
        // mass equal to minus frame energy passes too
        set_frame(32'hfffe0000, 32'h10000, 32'h0, 32'h0, 32'h20000);
        send_vector(lbfv_pkg::CMD_INTO, 32'h50000, 32'h1, 32'hffffffff, 32'h0);
        send_vector(lbfv_pkg::CMD_OUT, 32'h7fffffff, 32'h80000000, 32'h0, 32'h1);
        // extreme frame, tiny mass: forces saturation
        set_frame(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h1);
        send_vector(lbfv_pkg::CMD_INTO, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h1);
        send_vector(lbfv_pkg::CMD_OUT, 32'h80000000, 32'h80000000, 32'h7fffffff,
                    32'hffffffff);
        set_frame(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_vector(lbfv_pkg::CMD_INTO, 32'h10000, 32'h20000, 32'h30000, 32'h40000);
        send_vector(lbfv_pkg::CMD_OUT, 32'h10000, 32'h20000, 32'h30000, 32'h40000);
    endtask

    task automatic test_random_frames();
        for (int ph = 0; ph < 8; ph++) begin
            set_frame(rand_word(), rand_word(), rand_word(), rand_word(),
                      ph == 3 ? 32'h0 : rand_word());
            repeat (180) send_vector($urandom_range(0, 1), rand_word(), rand_word(),
                                     rand_word(), rand_word());
        end
    endtask

    task automatic test_backpressure();
        set_frame(32'h18000, 32'h4000, 32'hffffc000, 32'h2000, 32'h10000);
        hold_off = 400;
        repeat (200) send_vector($urandom_range(0, 1), rand_word(), rand_word(),
                                 rand_word(), rand_word(), 1'b0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_frames();
        test_backpressure();
        wait_drained();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
